// ===== design/edge_weighted_scatter_aggregate_defines.svh =====
// assertion macros for the scatter aggregation block
`ifndef EDGE_WEIGHTED_SCATTER_AGGREGATE_DEFINES_SVH
`define EDGE_WEIGHTED_SCATTER_AGGREGATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define EWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ews_pkg.sv =====
// types and constants shared by the scatter aggregation modules
`default_nettype none
package ews_pkg;

    localparam int NODES       = 256;
    localparam int FEATURES    = 16;
    localparam int MAX_OUT     = 16;
    localparam int FEAT_LIMIT  = (FEATURES < MAX_OUT) ? FEATURES : MAX_OUT;
    localparam int NODE_W      = 8;
    localparam int COL_W       = 4;
    localparam int NF_W        = 5;
    localparam int VAL_W       = 16;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 32;
    localparam int DEG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NF        = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [NODE_W-1:0]        node_index;
        logic [COL_W-1:0]         feature_index;
        logic signed [VAL_W-1:0]  feature_value;
        logic [NODE_W-1:0]        src_node;
        logic [NODE_W-1:0]        dst_node;
        logic signed [VAL_W-1:0]  msg_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0]  agg_value;
        logic [COL_W-1:0]         out_feature;
        logic                     last;
    } t_out_item;

    // classified command handed from the front to the back
    typedef struct packed {
        t_mode                    kind;
        logic [NODE_W-1:0]        node;
        logic [NODE_W-1:0]        src;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  data;
        logic [NF_W-1:0]          nf;
        logic                     mean;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic idle;
    } t_bk_stat;

endpackage
`default_nettype wire

// ===== design/ews_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module ews_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/ews_front.sv =====
// front end: config registers, item classification and a two-entry command queue
`default_nettype none
module ews_front import ews_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_in_item              i_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_pop,
    output t_cmd                       o_cmd,
    output t_q_stat                    o_stat
);

    localparam int QD = 2;

    logic            r_mean;
    logic [NF_W-1:0] r_nf;
    logic [NF_W-1:0] n_nf_eff;

    t_cmd            r_q [QD];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    t_cmd            n_cmd;
    logic            n_keep;
    logic            n_push;

    always_comb begin
        if (r_nf == '0) begin
            n_nf_eff = NF_W'(1);
        end else if (32'(r_nf) > FEAT_LIMIT) begin
            n_nf_eff = NF_W'(FEAT_LIMIT);
        end else begin
            n_nf_eff = r_nf;
        end
    end

    always_comb begin
        n_cmd      = '0;
        n_cmd.kind = i_item.mode;
        n_cmd.nf   = n_nf_eff;
        n_cmd.mean = r_mean;
        n_keep     = 1'b1;
        unique case (i_item.mode)
            MODE_LOAD: begin
                n_cmd.node = i_item.node_index;
                n_cmd.col  = i_item.feature_index;
                n_cmd.data = i_item.feature_value;
                n_keep     = (32'(i_item.node_index) < NODES)
                          && (32'(i_item.feature_index) < FEATURES);
            end
            MODE_EDGE: begin
                n_cmd.node = i_item.dst_node;
                n_cmd.src  = i_item.src_node;
                n_cmd.data = i_item.msg_weight;
                n_keep     = (32'(i_item.dst_node) < NODES)
                          && (32'(i_item.src_node) < NODES);
            end
            MODE_READ: begin
                n_cmd.node = i_item.node_index;
                n_keep     = 32'(i_item.node_index) < NODES;
            end
            MODE_CLEAR: begin
                n_keep = 1'b1;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_stat.full  = (r_cnt == 2'(QD));
    assign o_stat.empty = (r_cnt == 2'd0);
    // out-of-range items are taken but dropped
    assign n_push = i_start && !o_stat.full && n_keep;
    assign o_cmd  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= 1'b0;
            r_nf   <= NF_W'(16);
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NORMALIZE: r_mean <= i_cfg_data[0];
                    CFG_NF:        r_nf   <= i_cfg_data;
                    default:       r_nf   <= r_nf;
                endcase
            end
            if (n_push) begin
                r_q[r_wp] <= n_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(n_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/ews_div.sv =====
// bit-serial signed by unsigned divider, truncating toward zero
`default_nettype none
module ews_div import ews_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_dividend,
    input  wire logic [DEG_W-1:0]        i_divisor,
    output logic                         o_done,
    output logic signed [ACC_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(ACC_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [ACC_W-1:0] r_quo;
    logic [DEG_W-1:0] r_rem;
    logic [DEG_W-1:0] r_div;

    logic [DEG_W:0]   n_rem_sh;
    logic             n_bit;
    logic [DEG_W:0]   n_rem;

    always_comb begin
        n_rem_sh = {r_rem, r_quo[ACC_W-1]};
        n_bit    = n_rem_sh >= {1'b0, r_div};
        n_rem    = n_bit ? (n_rem_sh - {1'b0, r_div}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[ACC_W-1];
                r_quo  <= i_dividend[ACC_W-1] ? -i_dividend : i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem[DEG_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], n_bit};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule
`default_nettype wire

// ===== design/ews_back.sv =====
// back end: feature, accumulator and degree stores and the per-item sequencer
`default_nettype none
module ews_back import ews_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_cmd_valid,
    output logic       o_pop,
    output logic       o_res_strobe,
    output t_out_item  o_result,
    output t_bk_stat   o_stat
);

    localparam int AW = NODE_W + COL_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_CLEAR, S_EDGE, S_EDRAIN, S_RD, S_RDW, S_DIV
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [COL_W-1:0]         r_col;
    logic [NODES-1:0]         r_row_valid;

    logic                     r_p1_v;
    logic [COL_W-1:0]         r_p1_col;
    logic                     r_p1_keep;
    logic                     r_p2_v;
    logic [COL_W-1:0]         r_p2_col;
    logic                     r_p2_keep;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_old;
    logic [DEG_W-1:0]         r_deg_old;

    logic                     r_res_strobe;
    t_out_item                r_result;

    logic [VAL_W-1:0]         w_feat_q;
    logic [ACC_W-1:0]         w_acc_q;
    logic [DEG_W-1:0]         w_deg_q;

    logic                     n_acc_we;
    logic [ACC_W-1:0]         n_acc_wdata;
    logic signed [ACC_W:0]    n_sum;
    logic                     n_deg_we;
    logic [DEG_W-1:0]         n_deg_wdata;
    logic                     n_row_ok;
    logic signed [ACC_W-1:0]  n_rd_val;
    logic [DEG_W-1:0]         n_rd_cnt;
    logic                     n_rd_last;
    logic                     n_div_start;
    logic                     w_div_done;
    logic signed [ACC_W-1:0]  w_div_q;

    assign n_row_ok = r_row_valid[r_cmd.node];

    // accumulate with saturation at the signed 48-bit limits; columns not in use are written back unchanged
    always_comb begin
        n_sum = {r_acc_old[ACC_W-1], r_acc_old} + (ACC_W+1)'(r_prod);
        if (r_p2_keep) begin
            n_acc_wdata = r_acc_old;
        end else if (n_sum[ACC_W] != n_sum[ACC_W-1]) begin
            n_acc_wdata = n_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc_wdata = n_sum[ACC_W-1:0];
        end
        n_acc_we = r_p2_v;
    end

    always_comb begin
        n_deg_we    = (r_state == S_EDRAIN) && !r_p1_v && !r_p2_v;
        n_deg_wdata = (r_deg_old == '1) ? r_deg_old : r_deg_old + DEG_W'(1);
    end

    always_comb begin
        n_rd_val  = n_row_ok ? w_acc_q : '0;
        n_rd_cnt  = n_row_ok ? w_deg_q : '0;
        if (n_rd_cnt == '0) begin
            n_rd_cnt = DEG_W'(1);
        end
        n_rd_last   = ({1'b0, r_col} + NF_W'(1)) == r_cmd.nf;
        n_div_start = (r_state == S_RDW) && r_cmd.mean;
    end

    assign o_pop = (r_state == S_IDLE) && i_cmd_valid;

    ews_ram #(.WIDTH(VAL_W), .DEPTH(NODES * FEATURES)) u_feat (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr ({r_cmd.node, r_cmd.col}),
        .i_wdata (r_cmd.data),
        .i_raddr ({r_cmd.src, r_col}),
        .o_rdata (w_feat_q)
    );

    ews_ram #(.WIDTH(ACC_W), .DEPTH(NODES * FEATURES)) u_acc (
        .i_clk   (i_clk),
        .i_we    (n_acc_we),
        .i_waddr ({r_cmd.node, r_p2_col}),
        .i_wdata (n_acc_wdata),
        .i_raddr ({r_cmd.node, r_col}),
        .o_rdata (w_acc_q)
    );

    ews_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_deg (
        .i_clk   (i_clk),
        .i_we    (n_deg_we),
        .i_waddr (r_cmd.node),
        .i_wdata (n_deg_wdata),
        .i_raddr (r_cmd.node),
        .o_rdata (w_deg_q)
    );

    ews_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_rd_val),
        .i_divisor  (n_rd_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row_valid  <= '0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= 1'b0;

            // edge pipeline: read, multiply, accumulate and write back
            r_p1_v    <= (r_state == S_EDGE);
            r_p1_col  <= r_col;
            r_p1_keep <= ({1'b0, r_col} >= r_cmd.nf);
            r_p2_v    <= r_p1_v;
            r_p2_col  <= r_p1_col;
            r_p2_keep <= r_p1_keep;
            r_prod    <= $signed(w_feat_q) * r_cmd.data;
            r_acc_old <= n_row_ok ? w_acc_q : '0;
            if (r_p1_v && (r_p1_col == '0)) begin
                r_deg_old <= n_row_ok ? w_deg_q : '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_col <= '0;
                        unique case (i_cmd.kind)
                            MODE_LOAD:  r_state <= S_LOAD;
                            MODE_EDGE:  r_state <= S_EDGE;
                            MODE_READ:  r_state <= S_RD;
                            MODE_CLEAR: r_state <= S_CLEAR;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_row_valid <= '0;
                    r_state     <= S_IDLE;
                end
                S_EDGE: begin
                    // every column is rewritten so a fresh row is fully defined
                    r_col <= r_col + COL_W'(1);
                    if (r_col == COL_W'(FEATURES - 1)) begin
                        r_state <= S_EDRAIN;
                    end
                end
                S_EDRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_row_valid[r_cmd.node] <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    if (r_cmd.mean) begin
                        r_state <= S_DIV;
                    end else begin
                        r_res_strobe         <= 1'b1;
                        r_result.agg_value   <= n_rd_val;
                        r_result.out_feature <= r_col;
                        r_result.last        <= n_rd_last;
                        r_col                <= r_col + COL_W'(1);
                        r_state              <= n_rd_last ? S_IDLE : S_RD;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_strobe         <= 1'b1;
                        r_result.agg_value   <= w_div_q;
                        r_result.out_feature <= r_col;
                        r_result.last        <= n_rd_last;
                        r_col                <= r_col + COL_W'(1);
                        r_state              <= n_rd_last ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_result     = r_result;
    assign o_stat.idle  = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ===== design/edge_weighted_scatter_aggregate.sv =====
// top level of the edge-weighted scatter aggregation block
//
// items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. a front end checks node and column ranges and queues up to two
// commands; the back end works through them one at a time.
// config writes (normalize_mean, features_in_use) go through i_cfg_valid with
// o_cfg_ready always high; the user must make them only while the block is
// idle, as the block itself does not enforce this. in the back end, a feature
// load writes the feature store, a clear resets the row valid bits, an edge runs
// all 16 columns and drains the read/multiply/write pipeline, and a read in mean
// mode divides each feature by its count in a 48-step serial divider.
// a read gives one result per feature in use on o_res_strobe, one cycle each,
// with last on the final one; the receiver cannot stall these.
// reset restores the config registers (sum mode, 16 features in use), empties
// the queue and clears the row valid bits, so all accumulators and counts read as
// zero at once; the feature store is undefined until loaded.
`default_nettype none
`include "edge_weighted_scatter_aggregate_defines.svh"
module edge_weighted_scatter_aggregate import ews_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in_item              i_item,
    output logic                       o_res_strobe,
    output t_out_item                  o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd     w_cmd;
    t_q_stat  w_q_stat;
    t_bk_stat w_bk_stat;
    logic     w_pop;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_q_stat.full;

    ews_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (w_pop),
        .o_cmd       (w_cmd),
        .o_stat      (w_q_stat)
    );

    ews_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_valid  (!w_q_stat.empty),
        .o_pop        (w_pop),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .o_stat       (w_bk_stat)
    );

    `EWS_ASSERT_NEXT(a_take_queued, i_clk, i_rst_n, start && !busy, !w_q_stat.empty, "accepted item not queued")
    `EWS_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_res_strobe, !o_res_strobe, "results on back-to-back cycles")
    `EWS_ASSERT_NEXT(a_back_picks, i_clk, i_rst_n, w_bk_stat.idle && !w_q_stat.empty, !w_bk_stat.idle, "queued item left waiting")

endmodule
`default_nettype wire
